[rtl/cd_disc_id_builder_top_assert.svh]
// ----------------------------------------------------------------------------
// Disc id builder assertion macros
// Shared concurrent check forms used by the top level.
// ----------------------------------------------------------------------------
`ifndef CD_DISC_ID_BUILDER_TOP_ASSERT_SVH
`define CD_DISC_ID_BUILDER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDDB_CHECK_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CDDB_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/cddb_pkg.sv]
// ----------------------------------------------------------------------------
// Disc id builder package
// Item types, queue entry type and fixed arithmetic constants.
// ----------------------------------------------------------------------------
`default_nettype none

package cddb_pkg;

	localparam int OFFSET_W = 19;
	localparam int SECS_W   = 13;
	localparam int DSUM_W   = 6;
	localparam int ACC_W    = 12;
	localparam int COUNT_W  = 7;

	localparam logic MODE_TRACK   = 1'b0;
	localparam logic MODE_LEADOUT = 1'b1;

	// Reciprocal constants: (n * RECIP) >> SHIFT equals n / divisor for the used ranges.
	localparam int RECIP_75     = 447393;
	localparam int SHIFT_75     = 25;
	localparam int RECIP_10     = 6554;
	localparam int SHIFT_10     = 16;
	localparam int RECIP_100    = 5243;
	localparam int SHIFT_100    = 19;
	localparam int RECIP_1000   = 8389;
	localparam int SHIFT_1000   = 23;

	localparam int CHECKSUM_MOD = 255;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;

	typedef struct packed {
		logic                mode;
		logic [OFFSET_W-1:0] frame_offset;
	} in_item_t;

	typedef struct packed {
		logic [31:0]        disc_id;
		logic [7:0]         checksum_byte;
		logic [15:0]        total_seconds;
		logic [COUNT_W-1:0] track_count;
		logic               no_tracks;
	} out_item_t;

	typedef struct packed {
		logic              mode;
		logic [SECS_W-1:0] secs;
		logic [DSUM_W-1:0] digit_sum;
	} entry_t;

endpackage

`default_nettype wire

[rtl/cddb_in_if.sv]
// ----------------------------------------------------------------------------
// Table of contents channel
// Valid/ready channel carrying one track or leadout item per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface cddb_in_if;
	logic               valid;
	logic               ready;
	cddb_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/cddb_out_if.sv]
// ----------------------------------------------------------------------------
// Disc id channel
// Valid/ready channel carrying one finished disc id per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface cddb_out_if;
	logic                valid;
	logic                ready;
	cddb_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/cddb_front.sv]
// ----------------------------------------------------------------------------
// Disc id builder front end
// Accepts items, converts frames to seconds and splits seconds into digits.
// ----------------------------------------------------------------------------
`default_nettype none

module cddb_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	cddb_in_if.sink            toc,
	output cddb_pkg::entry_t   push_data,
	output logic               push_valid,
	input  wire logic          push_ready
);
	import cddb_pkg::*;

	logic                valid_s1;
	logic                mode_s1;
	logic [SECS_W-1:0]   secs_s1;
	logic                valid_s2;
	logic                mode_s2;
	logic [SECS_W-1:0]   secs_s2;
	logic [9:0]          q10_s2;
	logic [6:0]          q100_s2;
	logic [3:0]          q1000_s2;

	logic                adv_s1;
	logic                adv_s2;
	logic [37:0]         prod_75;
	logic [25:0]         prod_10;
	logic [25:0]         prod_100;
	logic [26:0]         prod_1000;
	logic [3:0]          d0;
	logic [3:0]          d1;
	logic [3:0]          d2;

	assign adv_s2    = !valid_s2 || push_ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign toc.ready = adv_s1;

	assign prod_75   = 38'(toc.data.frame_offset) * 38'(RECIP_75);
	assign prod_10   = 26'(secs_s1) * 26'(RECIP_10);
	assign prod_100  = 26'(secs_s1) * 26'(RECIP_100);
	assign prod_1000 = 27'(secs_s1) * 27'(RECIP_1000);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= toc.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && toc.valid) begin
			mode_s1 <= toc.data.mode;
			secs_s1 <= prod_75[SHIFT_75 +: SECS_W];
		end
		if (adv_s2 && valid_s1) begin
			mode_s2  <= mode_s1;
			secs_s2  <= secs_s1;
			q10_s2   <= prod_10[SHIFT_10 +: 10];
			q100_s2  <= prod_100[SHIFT_100 +: 7];
			q1000_s2 <= prod_1000[SHIFT_1000 +: 4];
		end
	end

	assign d0 = 4'(secs_s2 - (13'({q10_s2, 3'b000}) + 13'({q10_s2, 1'b0})));
	assign d1 = 4'(q10_s2 - (10'({q100_s2, 3'b000}) + 10'({q100_s2, 1'b0})));
	assign d2 = 4'(q100_s2 - (7'({q1000_s2, 3'b000}) + 7'({q1000_s2, 1'b0})));

	assign push_valid          = valid_s2;
	assign push_data.mode      = mode_s2;
	assign push_data.secs      = secs_s2;
	assign push_data.digit_sum = DSUM_W'(d0) + DSUM_W'(d1) + DSUM_W'(d2) + DSUM_W'(q1000_s2);

endmodule

`default_nettype wire

[rtl/cddb_fifo.sv]
// ----------------------------------------------------------------------------
// Disc id builder queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cddb_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cddb_pkg::entry_t  push_data,
	input  wire logic              push_valid,
	output logic                   push_ready,
	output cddb_pkg::entry_t       pop_data,
	output logic                   pop_valid,
	input  wire logic              pop_ready
);
	import cddb_pkg::*;

	entry_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_AW:0]     count_q;
	logic                  do_push;
	logic                  do_pop;

	assign push_ready = count_q != (QUEUE_AW+1)'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

[rtl/cddb_back.sv]
// ----------------------------------------------------------------------------
// Disc id builder back end
// Accumulates track data and forms the disc id on each leadout item.
// ----------------------------------------------------------------------------
`default_nettype none

module cddb_back #(
	parameter int MAX_TRACKS = 99
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cddb_pkg::entry_t  pop_data,
	input  wire logic              pop_valid,
	output logic                   pop_ready,
	cddb_out_if.source             disc
);
	import cddb_pkg::*;

	logic [ACC_W-1:0]    dsum_q;
	logic [SECS_W-1:0]   first_q;
	logic [COUNT_W-1:0]  tracks_q;
	logic                out_valid_q;
	out_item_t           out_q;

	logic                out_free;
	logic                do_pop;
	logic                is_leadout;
	logic                has_room;
	logic [8:0]          fold;
	logic [7:0]          chk;
	logic [15:0]         tot;
	out_item_t           res;

	assign is_leadout = pop_data.mode == MODE_LEADOUT;
	assign out_free   = !out_valid_q || disc.ready;
	assign pop_ready  = !is_leadout || out_free;
	assign do_pop     = pop_valid && pop_ready;
	assign has_room   = tracks_q < COUNT_W'(MAX_TRACKS);

	// Since 256 is one more than 255, folding the high nibble onto the low byte keeps the residue.
	assign fold = 9'(dsum_q[ACC_W-1:8]) + 9'(dsum_q[7:0]);
	assign chk  = (fold >= 9'(CHECKSUM_MOD)) ? 8'(fold - 9'(CHECKSUM_MOD)) : fold[7:0];
	assign tot  = 16'(pop_data.secs) - 16'(first_q);

	always_comb begin
		res = '0;
		if (tracks_q == '0) begin
			res.no_tracks = 1'b1;
		end else begin
			res.checksum_byte = chk;
			res.total_seconds = tot;
			res.track_count   = tracks_q;
			res.disc_id       = {chk, tot, 1'b0, tracks_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dsum_q      <= '0;
			first_q     <= '0;
			tracks_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_pop) begin
				if (is_leadout) begin
					dsum_q   <= '0;
					first_q  <= '0;
					tracks_q <= '0;
				end else if (has_room) begin
					if (tracks_q == '0) begin
						first_q <= pop_data.secs;
					end
					dsum_q   <= dsum_q + ACC_W'(pop_data.digit_sum);
					tracks_q <= tracks_q + 1'b1;
				end
			end
			if (do_pop && is_leadout) begin
				out_valid_q <= 1'b1;
			end else if (disc.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop && is_leadout) begin
			out_q <= res;
		end
	end

	assign disc.valid = out_valid_q;
	assign disc.data  = out_q;

endmodule

`default_nettype wire

[rtl/cd_disc_id_builder_top.sv]
// A leadout transfer passes the two front-end stage registers, the queue and the output register.
// Throughput: one item per cycle through the two-stage frame-to-digits front end, unless a full queue stalls it.
// A stalled result holds the back end only on leadout items; the front keeps filling the queue.
// Reset clears all valid bits, queue pointers and the accumulated disc state.
// ----------------------------------------------------------------------------
// Disc id builder top level
// Front end, queue and back end that turn a table of contents into a disc id.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cd_disc_id_builder_top_assert.svh"

module cd_disc_id_builder_top #(
	parameter int MAX_TRACKS = 99
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	cddb_in_if.sink    toc,
	cddb_out_if.source disc
);
	import cddb_pkg::*;

	entry_t push_data;
	logic   push_valid;
	logic   push_ready;
	entry_t pop_data;
	logic   pop_valid;
	logic   pop_ready;

	cddb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.toc        (toc),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	cddb_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_data   (pop_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	cddb_back #(
		.MAX_TRACKS (MAX_TRACKS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_data  (pop_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.disc      (disc)
	);

	`CDDB_CHECK_NOW(a_id_packing, disc.valid, (disc.data.disc_id == {disc.data.checksum_byte, disc.data.total_seconds, 1'b0, disc.data.track_count}), "disc id does not match its fields")
	`CDDB_CHECK_NOW(a_empty_disc, (disc.valid && disc.data.no_tracks), (disc.data.disc_id == 32'd0), "empty disc carries a nonzero id")
	`CDDB_CHECK_NOW(a_field_range, disc.valid, ((disc.data.checksum_byte != 8'(CHECKSUM_MOD)) && (disc.data.track_count <= COUNT_W'(MAX_TRACKS))), "disc id field out of range")
	`CDDB_CHECK_NEXT(a_result_hold, (disc.valid && !disc.ready), (disc.valid && $stable(disc.data)), "stalled disc id changed")

endmodule

`default_nettype wire
